// ----- design/wsdf_pkg.sv -----
// Package for the WebSocket frame deframer: field widths, parse phases and the result record.
package wsdf_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned OpcodeW  = 4;
	localparam int unsigned LenW     = 64;
	localparam int unsigned KeyW     = 32;
	localparam int unsigned HdrCntW  = 4;
	localparam int unsigned KeyPosW  = 2;
	localparam int unsigned OutDataW = 16;

	// Seven-bit length codes that announce an extended length
	localparam logic [6:0] Len7Ext16 = 7'd126;
	localparam logic [6:0] Len7Ext64 = 7'd127;

	// Extended-length and key byte counts
	localparam logic [HdrCntW-1:0] Ext16Bytes = 4'd2;
	localparam logic [HdrCntW-1:0] Ext64Bytes = 4'd8;
	localparam logic [HdrCntW-1:0] KeyBytes   = 4'd4;

	// Parse phases
	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// One result item
	typedef struct packed {
		logic               empty_frame;
		logic               is_last;
		logic               final_fragment;
		logic [OpcodeW-1:0] frame_opcode;
		logic [ByteW-1:0]   payload_byte;
	} result_t;

endpackage

// ----- design/websocket_frame_deframer.sv -----
// WebSocket frame deframer: header parse, length and key capture, payload unmasking.
//
//  channel   | dir | tdata (low bit up)                               | tuser       | tlast
//  s_axis    | in  | in_byte[7:0]                                     | -           | -
//  m_axis    | out | payload_byte[7:0], frame_opcode[11:8], fin[12]  | empty_frame | is_last
//
//  One byte per clock sustained while m_axis does not stall; a result is registered after its byte is accepted
//  (input register, then parse logic into the result register).
//  Every byte is taken at one a clock when not stalled: the parse logic is a single pass on the 64-bit length.
//  arst_n clears the parse state and the valid bits of both register stages.
//  A stall on m_axis holds the result register and the input register; s_axis_tready
//  drops only while both are full and the result is not being taken.
module websocket_frame_deframer
	import wsdf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] in_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
	                                            // [12] final_fragment, [15:13] zero
	output logic                m_axis_tlast,   // is_last
	output logic                m_axis_tuser    // [0] empty_frame
);

	// Pipeline and parse state
	logic                 valid_s1;
	logic [ByteW-1:0]     byte_s1;
	logic                 out_valid_q;
	result_t              out_q;

	phase_t               phase_q, phase_d;
	logic                 fin_q, fin_d;
	logic [OpcodeW-1:0]   opcode_q, opcode_d;
	logic                 mask_q, mask_d;
	logic [LenW-1:0]      rem_q, rem_d;
	logic [HdrCntW-1:0]   hbl_q, hbl_d;
	logic [KeyW-1:0]      key_q, key_d;
	logic [KeyPosW-1:0]   kpos_q, kpos_d;

	logic                 advance;
	logic                 update;
	logic                 res_valid;
	result_t              res;
	logic                 len_done;
	logic [ByteW-1:0]     key_byte;

	// Handshake: result register frees when empty or taken
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign update        = valid_s1 && advance;

	// Key byte for the current payload position, first key byte in the top
	always_comb begin
		case (kpos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Parse one byte
	always_comb begin
		phase_d   = phase_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		mask_d    = mask_q;
		rem_d     = rem_q;
		hbl_d     = hbl_q;
		key_d     = key_q;
		kpos_d    = kpos_q;
		len_done  = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_SECOND: begin
				mask_d = byte_s1[7];
				rem_d  = '0;
				if (byte_s1[6:0] == Len7Ext16) begin
					hbl_d   = Ext16Bytes;
					phase_d = PH_EXTLEN;
				end else if (byte_s1[6:0] == Len7Ext64) begin
					hbl_d   = Ext64Bytes;
					phase_d = PH_EXTLEN;
				end else begin
					rem_d    = {{(LenW-7){1'b0}}, byte_s1[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				rem_d = {rem_q[LenW-ByteW-1:0], byte_s1};
				hbl_d = hbl_q - 4'd1;
				if (hbl_q == 4'd1) begin
					len_done = 1'b1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[KeyW-ByteW-1:0], byte_s1};
				hbl_d = hbl_q - 4'd1;
				if (hbl_q == 4'd1) begin
					if (rem_q == '0) begin
						phase_d   = PH_FIRST;
						res_valid = 1'b1;
						res.is_last     = 1'b1;
						res.empty_frame = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				kpos_d    = kpos_q + 2'd1;
				rem_d     = rem_q - 64'd1;
				res_valid = 1'b1;
				res.payload_byte = mask_q ? (byte_s1 ^ key_byte) : byte_s1;
				if (rem_q == 64'd1) begin
					phase_d     = PH_FIRST;
					res.is_last = 1'b1;
				end
			end
			default: begin
				fin_d    = byte_s1[7];
				opcode_d = byte_s1[OpcodeW-1:0];
				phase_d  = PH_SECOND;
			end
		endcase

		// Length known: key next, payload next, or an empty frame ends here
		if (len_done) begin
			kpos_d = '0;
			if (mask_d) begin
				hbl_d   = KeyBytes;
				phase_d = PH_KEY;
			end else if (rem_d == '0) begin
				phase_d   = PH_FIRST;
				res_valid = 1'b1;
				res.is_last     = 1'b1;
				res.empty_frame = 1'b1;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		res.frame_opcode   = opcode_q;
		res.final_fragment = fin_q;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			rem_q    <= '0;
			hbl_q    <= '0;
			key_q    <= '0;
			kpos_q   <= '0;
		end else if (update) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			rem_q    <= rem_d;
			hbl_q    <= hbl_d;
			key_q    <= key_d;
			kpos_q   <= kpos_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= update && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OutDataW-ByteW-OpcodeW-1){1'b0}}, out_q.final_fragment,
	                        out_q.frame_opcode, out_q.payload_byte};
	assign m_axis_tlast  = out_q.is_last;
	assign m_axis_tuser  = out_q.empty_frame;

	// Checks
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
		else $error("empty frame result without last mark or with nonzero data");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with zero bytes remaining");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXTLEN || phase_q == PH_KEY) |-> hbl_q != '0)
		else $error("header byte count exhausted inside header phase");

	a_no_result_first: assert property (@(posedge clk) disable iff (!arst_n)
		update && res_valid |-> phase_q != PH_FIRST)
		else $error("result raised on a first header byte");

endmodule

// ----- test/tb.sv -----
// Testbench for websocket_frame_deframer: directed frames, then random frames checked by a predictor.
module tb
	import wsdf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ByteTarget = 1050;
	localparam int unsigned StallLimit = 2000;
	localparam int unsigned DrainCycles = 8;

	// Directed row: byte to send, whether its outcome is typed in, and that outcome
	typedef struct packed {
		logic [ByteW-1:0] b;
		logic             typed;
		logic             has;
		result_t          r;
	} dir_row_t;

	localparam result_t NoRes = '0;

	localparam dir_row_t DirRows [24] = '{
		// ping, fin set, unmasked, empty payload
		'{8'h89, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b1, 1'b1, result_t'({1'b1, 1'b1, 1'b1, 4'h9, 8'h00})},
		// binary, fin clear, one unmasked byte passed straight through
		'{8'h02, 1'b0, 1'b0, NoRes},
		'{8'h01, 1'b0, 1'b0, NoRes},
		'{8'hFF, 1'b1, 1'b1, result_t'({1'b0, 1'b1, 1'b0, 4'h2, 8'hFF})},
		// close with reserved bits set, masked, 64-bit form of a zero length
		'{8'hF8, 1'b0, 1'b0, NoRes},
		'{8'hFF, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'hA5, 1'b0, 1'b0, NoRes},
		'{8'h5A, 1'b0, 1'b0, NoRes},
		'{8'h0F, 1'b0, 1'b0, NoRes},
		'{8'hF0, 1'b1, 1'b1, result_t'({1'b1, 1'b1, 1'b1, 4'h8, 8'h00})},
		// reserved opcode, 16-bit form, one unmasked byte
		'{8'h8F, 1'b0, 1'b0, NoRes},
		'{8'h7E, 1'b0, 1'b0, NoRes},
		'{8'h00, 1'b0, 1'b0, NoRes},
		'{8'h01, 1'b0, 1'b0, NoRes},
		'{8'hAB, 1'b1, 1'b1, result_t'({1'b0, 1'b1, 1'b1, 4'hF, 8'hAB})}
	};

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [ByteW-1:0]    s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                m_axis_tlast;
	logic                m_axis_tuser;

	// Predictor state
	phase_t             pr_phase  = PH_FIRST;
	logic               pr_fin    = 1'b0;
	logic [OpcodeW-1:0] pr_opcode = '0;
	logic               pr_masked = 1'b0;
	logic [LenW-1:0]    pr_remain = '0;
	logic [HdrCntW-1:0] pr_hdr    = '0;
	logic [KeyW-1:0]    pr_key    = '0;
	logic [KeyPosW-1:0] pr_keypos = '0;

	result_t     results_due [$];
	int unsigned errors     = 0;
	int unsigned in_count   = 0;
	bit          tx_burst   = 1'b0;
	bit          rx_burst   = 1'b0;

	websocket_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result for a frame with nothing in its payload
	function automatic result_t empty_result();
		result_t r;
		r = '0;
		r.frame_opcode   = pr_opcode;
		r.final_fragment = pr_fin;
		r.is_last        = 1'b1;
		r.empty_frame    = 1'b1;
		return r;
	endfunction

	// Length fully known: move on to the key, the payload, or close an empty frame
	function automatic bit length_known(output result_t r);
		r = '0;
		pr_keypos = '0;
		if (pr_masked) begin
			pr_hdr   = KeyBytes;
			pr_phase = PH_KEY;
			return 1'b0;
		end
		if (pr_remain == '0) begin
			pr_phase = PH_FIRST;
			r = empty_result();
			return 1'b1;
		end
		pr_phase = PH_PAYLOAD;
		return 1'b0;
	endfunction

	// Advance the deframer model by one byte; returns 1 when a result is due
	function automatic bit deframe_byte(input logic [ByteW-1:0] b, output result_t r);
		logic [ByteW-1:0] kb;
		int               sh;
		r = '0;
		case (pr_phase)
			PH_SECOND: begin
				pr_masked = b[7];
				pr_remain = '0;
				if (b[6:0] == Len7Ext16) begin
					pr_hdr   = Ext16Bytes;
					pr_phase = PH_EXTLEN;
					return 1'b0;
				end
				if (b[6:0] == Len7Ext64) begin
					pr_hdr   = Ext64Bytes;
					pr_phase = PH_EXTLEN;
					return 1'b0;
				end
				pr_remain = LenW'(b[6:0]);
				return length_known(r);
			end
			PH_EXTLEN: begin
				pr_remain = {pr_remain[LenW-9:0], b};
				pr_hdr    = pr_hdr - 4'd1;
				if (pr_hdr != '0)
					return 1'b0;
				return length_known(r);
			end
			PH_KEY: begin
				pr_key = {pr_key[KeyW-9:0], b};
				pr_hdr = pr_hdr - 4'd1;
				if (pr_hdr != '0)
					return 1'b0;
				if (pr_remain == '0) begin
					pr_phase = PH_FIRST;
					r = empty_result();
					return 1'b1;
				end
				pr_phase = PH_PAYLOAD;
				return 1'b0;
			end
			PH_PAYLOAD: begin
				kb = '0;
				if (pr_masked) begin
					sh = (3 - int'(pr_keypos)) * 8;
					kb = pr_key[sh +: 8];
				end
				pr_keypos = pr_keypos + 2'd1;
				pr_remain = pr_remain - 64'd1;
				r.payload_byte   = b ^ kb;
				r.frame_opcode   = pr_opcode;
				r.final_fragment = pr_fin;
				r.is_last        = (pr_remain == '0);
				if (pr_remain == '0)
					pr_phase = PH_FIRST;
				return 1'b1;
			end
			default: begin
				// first header byte; RSV bits are ignored
				pr_fin    = b[7];
				pr_opcode = b[3:0];
				pr_phase  = PH_SECOND;
				return 1'b0;
			end
		endcase
	endfunction

	// Present one byte on s_axis after a random gap and wait for its transfer
	task automatic push_byte(input logic [ByteW-1:0] b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		if ($urandom_range(0, 49) == 0)
			tx_burst = !tx_burst;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		in_count++;
	endtask

	// Send a byte and queue whatever the predictor says it causes
	task automatic feed(input logic [ByteW-1:0] b);
		result_t r;
		bit      got;
		push_byte(b);
		got = deframe_byte(b, r);
		if (got)
			results_due.push_back(r);
	endtask

	// One frame: form 0 is the 7-bit length, 1 the 16-bit, 2 the 64-bit
	task automatic emit_frame(input logic [ByteW-1:0] b0, input bit masked,
			input logic [LenW-1:0] len, input int form, input int npay);
		int next;
		feed(b0);
		case (form)
			0: begin
				feed({masked, len[6:0]});
				next = 0;
			end
			1: begin
				feed({masked, Len7Ext16});
				next = 2;
			end
			default: begin
				feed({masked, Len7Ext64});
				next = 8;
			end
		endcase
		for (int i = next - 1; i >= 0; i--)
			feed(len[8*i +: 8]);
		if (masked)
			repeat (4) feed(ByteW'($urandom));
		repeat (npay) feed(ByteW'($urandom));
	endtask

	// Random frame: any first byte, mostly short lengths in all three forms
	task automatic random_frame();
		logic [ByteW-1:0] b0;
		bit               masked;
		int               pick;
		int               form;
		int               len;
		b0     = ByteW'($urandom);
		masked = 1'($urandom_range(0, 1));
		pick   = $urandom_range(0, 99);
		if (pick < 3) begin
			form = 0;
			len  = 125;
		end else if (pick < 12) begin
			form = 0;
			len  = 0;
		end else if (pick < 50) begin
			form = 0;
			len  = $urandom_range(1, 16);
		end else if (pick < 75) begin
			form = 1;
			len  = $urandom_range(0, 24);
		end else if (pick < 80) begin
			form = 1;
			len  = $urandom_range(126, 300);
		end else begin
			// non-minimal 64-bit form of a short length
			form = 2;
			len  = $urandom_range(0, 24);
		end
		emit_frame(b0, masked, LenW'(len), form, len);
	endtask

	// Stimulus
	initial begin : stimulus
		result_t r;
		bit      got;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DirRows[i]) begin
			push_byte(DirRows[i].b);
			got = deframe_byte(DirRows[i].b, r);
			if (DirRows[i].typed) begin
				if (DirRows[i].has)
					results_due.push_back(DirRows[i].r);
			end else if (got) begin
				results_due.push_back(r);
			end
		end

		while (in_count < ByteTarget)
			random_frame();
		// huge length with the top bit set, left open at the end of the run
		emit_frame(8'h82, 1'b1, 64'h8000_0000_0000_0000, 2, 20);
		s_axis_tvalid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// Result side: random back-pressure, compare each transfer with the oldest expectation
	initial begin : result_check
		int      w;
		result_t want;
		forever begin
			w = rx_burst ? 0 : $urandom_range(0, 9);
			if ($urandom_range(0, 49) == 0)
				rx_burst = !rx_burst;
			if (w > 0) begin
				m_axis_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			if (results_due.size() == 0) begin
				$error("result with none expected: tdata 0x%0h", m_axis_tdata);
				errors++;
			end else begin
				want = results_due.pop_front();
				check_field("payload_byte", 32'(want.payload_byte),
					32'(m_axis_tdata[7:0]));
				check_field("frame_opcode", 32'(want.frame_opcode),
					32'(m_axis_tdata[11:8]));
				check_field("final_fragment", 32'(want.final_fragment),
					32'(m_axis_tdata[12]));
				check_field("is_last", 32'(want.is_last), 32'(m_axis_tlast));
				check_field("empty_frame", 32'(want.empty_frame), 32'(m_axis_tuser));
			end
		end
	end

	// Watchdog: too long without any transfer on either side
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
					(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
design/wsdf_pkg.sv
design/websocket_frame_deframer.sv
test/tb.sv
